FILE: hdl/sfc_pkg.sv
// Package for the sphere/frustum classifier.
// Holds field widths, codes, result enums and the flag struct; no dependencies.
package sfc_pkg;

   localparam int COMP_W   = 32;
   localparam int RANGE_W  = 31;
   localparam int OPND_W   = COMP_W + 1;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int R2_W     = 2 * RANGE_W;
   localparam int CSR_IDX_W = 2;

   localparam logic KIND_CORNER = 1'b0;
   localparam logic KIND_PLANE  = 1'b1;

   localparam logic [2:0] PLANE_NEAR = 3'd0;
   localparam logic [2:0] PLANE_FAR  = 3'd1;

   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_Z     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      CLASS_OUTSIDE = 3'd0,
      CLASS_FILL    = 3'd1,
      CLASS_FAR     = 3'd2,
      CLASS_NEAR    = 3'd3,
      CLASS_INSIDE  = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      CULL_NONE  = 2'd0,
      CULL_FRONT = 2'd1,
      CULL_BACK  = 2'd2
   } cull_type;

   typedef struct packed {
      logic corner_beyond;
      logic plane_rejects;
      logic far_crossed;
      logic near_behind;
      logic any_crossed;
   } flags_type;

endpackage

FILE: hdl/sphere_frustum_classifier.sv
// Sphere/frustum classifier top level: operand stage, product stage, sum stage
// and a result register with the gathered frustum flags. Depends on sfc_pkg.
//
// Takes one request per clock unless stalled. Each passes an operand register, a
// register after three 33x33 multipliers (shared by corner squares and plane
// dot products), and a 68-bit sum register; the compares and flag update sit
// between the sum register and the result register. The result of a request
// marked last appears on rsp_valid once it reaches the result register.
// A held result stalls only requests marked last; the pipeline keeps filling
// behind it until all three stages are occupied.
module sphere_frustum_classifier
   import sfc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [2:0]           req_plane_index,
   input  logic signed [31:0]   req_comp_x,
   input  logic signed [31:0]   req_comp_y,
   input  logic signed [31:0]   req_comp_z,
   input  logic signed [31:0]   req_comp_w,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_position_class,
   output logic                 rsp_depth_greater,
   output logic [1:0]           rsp_cull_mode,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COMP_W-1:0]    csr_wdata
);

   localparam int PAD_W = SUM_W - COMP_W - FRAC_BITS;
   localparam int RS_PAD_W = SUM_W - RANGE_W - FRAC_BITS;

   // configuration
   logic signed [COMP_W-1:0] light_ff [3];
   logic [RANGE_W-1:0]       range_ff;
   logic [R2_W-1:0]          range_sq_ff;

   // stage 0: operands
   logic                     s0_valid_ff;
   logic                     s0_kind_ff;
   logic [2:0]               s0_pidx_ff;
   logic                     s0_last_ff;
   logic signed [OPND_W-1:0] s0_a_ff [3];
   logic signed [OPND_W-1:0] s0_b_ff [3];
   logic signed [COMP_W-1:0] s0_w_ff;

   // stage 1: products
   logic                     s1_valid_ff;
   logic                     s1_kind_ff;
   logic [2:0]               s1_pidx_ff;
   logic                     s1_last_ff;
   logic signed [PROD_W-1:0] s1_prod_ff [3];
   logic signed [SUM_W-1:0]  s1_w_ff;

   // stage 2: sum
   logic                     s2_valid_ff;
   logic                     s2_kind_ff;
   logic [2:0]               s2_pidx_ff;
   logic                     s2_last_ff;
   logic signed [SUM_W-1:0]  s2_sum_ff;

   flags_type                flags_ff, flags_in;

   logic                     rsp_valid_ff;
   class_type                rsp_class_ff, rsp_class_in;
   logic                     rsp_depth_ff, rsp_depth_in;
   cull_type                 rsp_cull_ff, rsp_cull_in;

   logic out_free, go2, free2, free1, free0;

   logic signed [COMP_W-1:0] req_comp [3];
   logic signed [OPND_W-1:0] a_in [3];
   logic signed [OPND_W-1:0] b_in [3];
   logic signed [SUM_W-1:0]  w_term;
   logic signed [SUM_W-1:0]  rs_pos, rs_neg, r2_ext;
   flags_type                hit;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign go2       = s2_valid_ff && (!s2_last_ff || out_free);
   assign free2     = !s2_valid_ff || go2;
   assign free1     = !s1_valid_ff || free2;
   assign free0     = !s0_valid_ff || free1;
   assign req_ready = free0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff[0] <= '0;
         light_ff[1] <= '0;
         light_ff[2] <= '0;
         range_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LIGHT_X:     light_ff[0] <= csr_wdata;
            REG_LIGHT_Y:     light_ff[1] <= csr_wdata;
            REG_LIGHT_Z:     light_ff[2] <= csr_wdata;
            REG_LIGHT_RANGE: range_ff    <= csr_wdata[RANGE_W-1:0];
            default:         range_ff    <= range_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      range_sq_ff <= R2_W'(range_ff) * R2_W'(range_ff);
   end

   // operand select
   assign req_comp[0] = req_comp_x;
   assign req_comp[1] = req_comp_y;
   assign req_comp[2] = req_comp_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (req_kind == KIND_CORNER) begin
            a_in[i] = {req_comp[i][COMP_W-1], req_comp[i]}
                    - {light_ff[i][COMP_W-1], light_ff[i]};
            b_in[i] = a_in[i];
         end else begin
            a_in[i] = {req_comp[i][COMP_W-1], req_comp[i]};
            b_in[i] = {light_ff[i][COMP_W-1], light_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (free0) begin
         s0_valid_ff <= req_valid;
      end
      if (free0 && req_valid) begin
         s0_kind_ff <= req_kind;
         s0_pidx_ff <= req_plane_index;
         s0_last_ff <= req_last;
         s0_a_ff    <= a_in;
         s0_b_ff    <= b_in;
         s0_w_ff    <= req_comp_w;
      end
   end

   // products
   assign w_term = (s0_kind_ff == KIND_PLANE) ?
                   {{PAD_W{s0_w_ff[COMP_W-1]}}, s0_w_ff, {FRAC_BITS{1'b0}}} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (free1) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (free1 && s0_valid_ff) begin
         s1_kind_ff <= s0_kind_ff;
         s1_pidx_ff <= s0_pidx_ff;
         s1_last_ff <= s0_last_ff;
         for (int i = 0; i < 3; i++) begin
            s1_prod_ff[i] <= PROD_W'(s0_a_ff[i]) * PROD_W'(s0_b_ff[i]);
         end
         s1_w_ff <= w_term;
      end
   end

   // sum
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (free2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (free2 && s1_valid_ff) begin
         s2_kind_ff <= s1_kind_ff;
         s2_pidx_ff <= s1_pidx_ff;
         s2_last_ff <= s1_last_ff;
         s2_sum_ff  <= SUM_W'(s1_prod_ff[0]) + SUM_W'(s1_prod_ff[1])
                     + SUM_W'(s1_prod_ff[2]) + s1_w_ff;
      end
   end

   // compare and gather
   assign rs_pos = {{RS_PAD_W{1'b0}}, range_ff, {FRAC_BITS{1'b0}}};
   assign rs_neg = -rs_pos;
   assign r2_ext = {{(SUM_W-R2_W){1'b0}}, range_sq_ff};

   always_comb begin
      hit = '0;
      if (s2_kind_ff == KIND_CORNER) begin
         hit.corner_beyond = s2_sum_ff > r2_ext;
      end else begin
         hit.plane_rejects = s2_sum_ff <= rs_neg;
         hit.any_crossed   = (s2_sum_ff > rs_neg) && (s2_sum_ff < rs_pos);
         hit.near_behind   = (s2_pidx_ff == PLANE_NEAR) && s2_sum_ff[SUM_W-1];
         hit.far_crossed   = (s2_pidx_ff == PLANE_FAR) && hit.any_crossed;
      end
      flags_in = flags_ff | hit;
   end

   always_comb begin
      if (!flags_in.corner_beyond) begin
         rsp_class_in = CLASS_FILL;    rsp_depth_in = 1'b0; rsp_cull_in = CULL_NONE;
      end else if (flags_in.plane_rejects) begin
         rsp_class_in = CLASS_OUTSIDE; rsp_depth_in = 1'b1; rsp_cull_in = CULL_FRONT;
      end else if (flags_in.far_crossed) begin
         rsp_class_in = CLASS_FAR;     rsp_depth_in = 1'b0; rsp_cull_in = CULL_BACK;
      end else if (flags_in.near_behind) begin
         rsp_class_in = CLASS_NEAR;    rsp_depth_in = 1'b0; rsp_cull_in = CULL_NONE;
      end else if (flags_in.any_crossed) begin
         rsp_class_in = CLASS_INSIDE;  rsp_depth_in = 1'b1; rsp_cull_in = CULL_FRONT;
      end else begin
         rsp_class_in = CLASS_OUTSIDE; rsp_depth_in = 1'b1; rsp_cull_in = CULL_FRONT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go2) begin
            flags_ff <= s2_last_ff ? '0 : flags_in;
         end
         if (out_free) begin
            rsp_valid_ff <= go2 && s2_last_ff;
         end
      end
      if (go2 && s2_last_ff) begin
         rsp_class_ff <= rsp_class_in;
         rsp_depth_ff <= rsp_depth_in;
         rsp_cull_ff  <= rsp_cull_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_class = rsp_class_ff;
   assign rsp_depth_greater  = rsp_depth_ff;
   assign rsp_cull_mode      = rsp_cull_ff;

   assert property (@(posedge clock) disable iff (reset)
      go2 && s2_last_ff |=> flags_ff == '0)
      else $error("flags not cleared after result");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s0_valid_ff && s1_valid_ff && s2_valid_ff)
      else $error("request refused with a free stage");

   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_last_ff && !go2 |-> rsp_valid_ff && !rsp_ready)
      else $error("final request held without a pending result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff == CLASS_FILL |-> rsp_cull_ff == CULL_NONE && !rsp_depth_ff)
      else $error("fill result with wrong depth or cull");

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for sphere_frustum_classifier: directed, random, back-pressure.
// Mirrors the flag accumulation and class priority in exact wide arithmetic.
// Depends on sfc_pkg and the classifier RTL only.
module tb_top;
   import sfc_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int PIPE_DEPTH = 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 800;
   localparam int RANDOM_PHASES = 8;
   localparam longint ONE = 64'sd65536;
   localparam longint COORD_SPAN = 64'sd1 <<< 26;
   localparam logic [2:0] PLANE_SIDE_FIRST = 3'd2;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic              kind;
      logic [2:0]        plane_index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] w;
      logic              last;
   } frustum_item_type;

   typedef struct {
      class_type position;
      logic      depth_greater;
      cull_type  cull;
   } light_class_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = 1'b0;
   logic [2:0]           req_plane_index = '0;
   logic signed [31:0]   req_comp_x = '0;
   logic signed [31:0]   req_comp_y = '0;
   logic signed [31:0]   req_comp_z = '0;
   logic signed [31:0]   req_comp_w = '0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_position_class;
   logic                 rsp_depth_greater;
   logic [1:0]           rsp_cull_mode;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COMP_W-1:0]    csr_wdata = '0;

   logic signed [31:0] light_x_q = '0;
   logic signed [31:0] light_y_q = '0;
   logic signed [31:0] light_z_q = '0;
   logic [30:0]        light_range_q = '0;
   flags_type          flags_q = '0;
   light_class_type    pending_classes[$];

   bit idle_on = 1'b1;
   bit hold_on = 1'b0;
   event hold_go;
   int cycle_count = 0;
   int error_count = 0;
   int requests_sent = 0;
   int classes_checked = 0;
   int csr_writes = 0;
   int class_seen[5] = '{default: 0};

   sphere_frustum_classifier #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_plane_index(req_plane_index),
      .req_comp_x(req_comp_x),
      .req_comp_y(req_comp_y),
      .req_comp_z(req_comp_z),
      .req_comp_w(req_comp_w),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_position_class(rsp_position_class),
      .rsp_depth_greater(rsp_depth_greater),
      .rsp_cull_mode(rsp_cull_mode),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold the receiver off on request.
   always begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_on <= 1'b0;
   end

   function automatic logic signed [127:0] widen(logic signed [31:0] v);
      return 128'(v);
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic longint rand_span(longint s);
      longint unsigned u;
      u = {$urandom, $urandom};
      return $signed(u % $unsigned(2 * s + 1)) - s;
   endfunction

   function automatic frustum_item_type corner_item(longint x, longint y, longint z,
                                                    bit last);
      frustum_item_type it;
      it.kind = KIND_CORNER;
      it.plane_index = 3'($urandom);
      it.x = clip32(x);
      it.y = clip32(y);
      it.z = clip32(z);
      it.w = $urandom;
      it.last = last;
      return it;
   endfunction

   function automatic frustum_item_type plane_item(logic [2:0] idx, longint a, longint b,
                                                   longint c, longint d, bit last);
      frustum_item_type it;
      it.kind = KIND_PLANE;
      it.plane_index = idx;
      it.x = clip32(a);
      it.y = clip32(b);
      it.z = clip32(c);
      it.w = clip32(d);
      it.last = last;
      return it;
   endfunction

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endfunction

   // Fold one accepted request into the flags; on last, queue the class and clear.
   function automatic void classify_request(frustum_item_type it);
      logic signed [33:0]  dx, dy, dz;
      logic [65:0]         ax, ay, az, dist2, reach2;
      logic signed [127:0] dot, lim;
      logic                crossed;
      light_class_type     res;
      if (it.kind == KIND_CORNER) begin
         dx = {{2{it.x[31]}}, it.x} - {{2{light_x_q[31]}}, light_x_q};
         dy = {{2{it.y[31]}}, it.y} - {{2{light_y_q[31]}}, light_y_q};
         dz = {{2{it.z[31]}}, it.z} - {{2{light_z_q[31]}}, light_z_q};
         ax = dx[33] ? 66'(-dx) : 66'(dx);
         ay = dy[33] ? 66'(-dy) : 66'(dy);
         az = dz[33] ? 66'(-dz) : 66'(dz);
         dist2 = ax * ax + ay * ay + az * az;
         reach2 = 66'(light_range_q) * 66'(light_range_q);
         if (dist2 > reach2) flags_q.corner_beyond = 1'b1;
      end else begin
         dot = widen(it.x) * widen(light_x_q) + widen(it.y) * widen(light_y_q)
             + widen(it.z) * widen(light_z_q) + (widen(it.w) <<< FRAC_BITS);
         lim = $signed({97'd0, light_range_q}) <<< FRAC_BITS;
         crossed = (dot > -lim) && (dot < lim);
         if (dot <= -lim) flags_q.plane_rejects = 1'b1;
         if (it.plane_index == PLANE_NEAR && dot < 0) flags_q.near_behind = 1'b1;
         if (it.plane_index == PLANE_FAR && crossed) flags_q.far_crossed = 1'b1;
         if (crossed) flags_q.any_crossed = 1'b1;
      end
      if (it.last) begin
         if (!flags_q.corner_beyond)    res = '{CLASS_FILL, 1'b0, CULL_NONE};
         else if (flags_q.plane_rejects) res = '{CLASS_OUTSIDE, 1'b1, CULL_FRONT};
         else if (flags_q.far_crossed)   res = '{CLASS_FAR, 1'b0, CULL_BACK};
         else if (flags_q.near_behind)   res = '{CLASS_NEAR, 1'b0, CULL_NONE};
         else if (flags_q.any_crossed)   res = '{CLASS_INSIDE, 1'b1, CULL_FRONT};
         else                            res = '{CLASS_OUTSIDE, 1'b1, CULL_FRONT};
         pending_classes.push_back(res);
         flags_q = '0;
      end
   endfunction

   task automatic push_request(frustum_item_type it);
      int gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_plane_index <= it.plane_index;
      req_comp_x <= it.x;
      req_comp_y <= it.y;
      req_comp_z <= it.z;
      req_comp_w <= it.w;
      req_last <= it.last;
      do @(posedge clock); while (!req_ready);
      classify_request(it);
      requests_sent++;
   endtask

   // Drop valid, drain all results, then let the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_classes.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [COMP_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_LIGHT_X:     light_x_q = data;
         REG_LIGHT_Y:     light_y_q = data;
         REG_LIGHT_Z:     light_z_q = data;
         REG_LIGHT_RANGE: light_range_q = data[30:0];
         default:         light_range_q = light_range_q;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure_light(longint x, longint y, longint z, logic [31:0] reach_word);
      write_csr(REG_LIGHT_X, clip32(x));
      write_csr(REG_LIGHT_Y, clip32(y));
      write_csr(REG_LIGHT_Z, clip32(z));
      write_csr(REG_LIGHT_RANGE, reach_word);
   endtask

   // Corners first, then near, far and side planes; broken ones are random in order.
   task automatic send_frustum(bit broken);
      longint           reach, spread, a, b, c, p, t;
      int               count, i;
      bit               is_plane, fill_shape, axis, last;
      logic [2:0]       idx;
      frustum_item_type it;
      reach = light_range_q;
      fill_shape = ($urandom_range(0, 3) == 0);
      spread = fill_shape ? reach / 2 : 3 * reach + 1;
      count = broken ? $urandom_range(1, 13) : 14;
      for (i = 0; i < count; i++) begin
         if (broken) begin
            is_plane = $urandom_range(0, 1);
            idx = 3'($urandom);
         end else begin
            is_plane = (i >= 8);
            if (i == 8) idx = PLANE_NEAR;
            else if (i == 9) idx = PLANE_FAR;
            else idx = PLANE_SIDE_FIRST + 3'(i - 10);
         end
         last = (i == count - 1) && !(broken && $urandom_range(0, 3) == 0);
         if (!is_plane) begin
            it = corner_item(light_x_q + rand_span(spread), light_y_q + rand_span(spread),
                             light_z_q + rand_span(spread), last);
         end else begin
            axis = $urandom_range(0, 1);
            a = axis ? (longint'($urandom_range(0, 2)) - 1) * ONE : rand_span(ONE);
            b = axis ? (longint'($urandom_range(0, 2)) - 1) * ONE : rand_span(ONE);
            c = axis ? (longint'($urandom_range(0, 2)) - 1) * ONE : rand_span(ONE);
            p = (a * light_x_q + b * light_y_q + c * light_z_q) >>> FRAC_BITS;
            case ($urandom_range(0, 7))
               0: t = -reach;
               1: t = reach;
               2: t = 0;
               3: t = -1;
               4: t = reach - 1;
               default: t = rand_span(2 * reach + 2);
            endcase
            it = plane_item(idx, a, b, c, t - p, last);
         end
         push_request(it);
      end
   endtask

   // Drop ready for a random stall drawn after each result, and while hold_on is set.
   initial begin : result_drain
      int              stall_left;
      bit              redraw;
      light_class_type want;
      stall_left = 0;
      redraw = 1'b1;
      forever begin
         @(negedge clock);
         if (redraw) begin
            stall_left = idle_on ? $urandom_range(0, 19) : 0;
            redraw = 1'b0;
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= !hold_on;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            redraw = 1'b1;
            if (pending_classes.size() == 0) begin
               note_error($sformatf("result class %0d with none expected",
                                    rsp_position_class));
            end else begin
               want = pending_classes.pop_front();
               classes_checked++;
               if (rsp_position_class < 5) class_seen[rsp_position_class]++;
               if (rsp_position_class !== want.position ||
                   rsp_depth_greater !== want.depth_greater ||
                   rsp_cull_mode !== want.cull)
                  note_error($sformatf("class %0d/%0d depth %0d/%0d cull %0d/%0d (exp/act)",
                                       want.position, rsp_position_class,
                                       want.depth_greater, rsp_depth_greater,
                                       want.cull, rsp_cull_mode));
            end
         end
      end
   end

   task automatic test_directed_classes();
      longint lx, ly, lz, beyond_x;
      settle();
      lx = 2 * ONE;
      ly = -3 * ONE;
      lz = ONE;
      beyond_x = lx + 100 * ONE;
      configure_light(lx, ly, lz, 32'(10 * ONE));
      idle_on = 1'b1;
      push_request(plane_item(PLANE_NEAR, 0, 0, 0, 0, 1));
      push_request(corner_item(lx + ONE, ly + ONE, lz + ONE, 0));
      push_request(corner_item(lx - ONE, ly, lz - ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_SIDE_FIRST, 0, 0, 0, -20 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_FAR, 0, 0, 0, 5 * ONE, 0));
      push_request(plane_item(PLANE_NEAR, 0, 0, 0, -5 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_NEAR, 0, 0, 0, -5 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_SIDE_FIRST + 3'd1, ONE, 0, 0, -2 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_SIDE_FIRST + 3'd4, 0, 0, 0, 50 * ONE, 0));
      push_request(plane_item(PLANE_SIDE_FIRST + 3'd5, 0, 0, 0, -3 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_SIDE_FIRST + 3'd3, 0, 0, 0, 50 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_SIDE_FIRST + 3'd2, 0, 0, 0, -10 * ONE, 1));
      push_request(corner_item(beyond_x, ly, lz, 0));
      push_request(plane_item(PLANE_FAR, 0, 0, 0, 10 * ONE, 1));
   endtask

   task automatic test_extreme_values();
      settle();
      configure_light(S32_MIN, S32_MAX, S32_MIN, 32'hFFFF_FFFF);
      push_request(corner_item(S32_MAX, S32_MIN, S32_MAX, 0));
      push_request(plane_item(PLANE_NEAR, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1));
      push_request(corner_item(S32_MIN, S32_MAX, S32_MIN, 1));
      settle();
      configure_light(S32_MAX, S32_MIN, S32_MIN, 32'd0);
      push_request(corner_item(S32_MAX, S32_MIN, S32_MIN, 1));
      push_request(corner_item(S32_MAX, S32_MIN, longint'(S32_MIN) + 1, 0));
      push_request(plane_item(PLANE_FAR, 0, 0, 0, 0, 1));
   endtask

   task automatic test_random_frustums();
      int               phase, budget, pick, n, i;
      logic [30:0]      reach;
      frustum_item_type it;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         reach = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 4095))
                                              : 31'($urandom_range(1, 1 << 24));
         if (phase == 0)
            configure_light(S32_MAX, S32_MIN, S32_MAX, 32'h7FFF_FFFF);
         else if (phase == 1)
            configure_light(rand_span(COORD_SPAN), rand_span(COORD_SPAN),
                            rand_span(COORD_SPAN), {1'($urandom), 31'd0});
         else
            configure_light(rand_span(COORD_SPAN), rand_span(COORD_SPAN),
                            rand_span(COORD_SPAN), {1'($urandom), reach});
         budget = requests_sent + ITEM_TARGET / RANDOM_PHASES;
         while (requests_sent < budget) begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
               send_frustum(1'b0);
            end else if (pick < 18) begin
               send_frustum(1'b1);
            end else begin
               n = $urandom_range(1, 6);
               for (i = 0; i < n; i++) begin
                  it.kind = 1'($urandom);
                  it.plane_index = 3'($urandom);
                  it.x = $urandom;
                  it.y = $urandom;
                  it.z = $urandom;
                  it.w = $urandom;
                  it.last = ($urandom_range(0, 5) == 0);
                  push_request(it);
               end
            end
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      int     i;
      longint reach;
      settle();
      reach = light_range_q;
      idle_on = 1'b0;
      -> hold_go;
      for (i = 0; i < 24; i++) begin
         if (i % 2 == 0)
            push_request(corner_item(light_x_q + rand_span(2 * reach),
                                     light_y_q + rand_span(2 * reach), light_z_q, 0));
         else
            push_request(plane_item(PLANE_FAR, 0, 0, 0, rand_span(2 * reach + 2), 1));
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_classes();
      test_extreme_values();
      test_random_frustums();
      test_backpressure();
      settle();
      $display("Covered %0d requests, %0d classes checked, %0d register writes",
               requests_sent, classes_checked, csr_writes);
      $display("Classes seen: outside %0d, fill %0d, far %0d, near %0d, inside %0d",
               class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
